// ===== src/tlic_pkg.sv =====
// Package for the interpolation table block: sizes, mode and status codes,
// and the saturation helpers used by the top level; the checker uses the codes.
// No dependencies.
package tlic_pkg;

    localparam int MAX_POINTS = 256;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int PT_CW      = $clog2(MAX_POINTS + 1);
    localparam int DVD_W      = 35;
    localparam int DIV_CW     = $clog2(DVD_W);

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_LOAD    = 2'd1;
    localparam logic [1:0] MODE_INTERP  = 2'd2;
    localparam logic [1:0] MODE_CORRECT = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_DIV0  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    function automatic logic out16(input logic signed [35:0] x);
        logic r;
        r = (x > 36'sd32767) || (x < -36'sd32768);
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] x);
        logic signed [15:0] r;
        if (x > 36'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (x < -36'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

// ===== src/table_linear_interpolate_correct_top.sv =====
// Interpolation table with sample correction, top level.
// Depends on tlic_pkg.
//
// Usage: a command is transferred when start is high and busy is low.
// mode 0 clears the table, mode 1 appends a (wavelength, value) point,
// mode 2 interpolates the table at wavelength, mode 3 divides sample_value
// times 4096 by the interpolated bias at wavelength.
// Each command gives exactly one result, shown for one cycle with done high.
// Modes 0 and 1: result the cycle after the transfer; busy stays low, so
// these commands can be issued every cycle.
// Modes 2 and 3: busy from the cycle after the transfer; busy drops in the
// cycle that shows the result.
// The point memory (one read port, registered read data) is walked one entry
// per cycle. An interpolation between two points then adds a multiply step,
// a 35-step restoring divider with setup and finish steps and a final step;
// a query that hits a stored point goes straight to the final step. A
// correction runs the divider once more.
// Reset clears the point count and control state; the memory is not cleared.
// The receiver cannot stall: results must be taken when done is high.
module table_linear_interpolate_correct_top
    import tlic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         mode,
    input  logic [15:0]        wavelength,
    input  logic signed [15:0] sample_value,
    output logic               busy,
    output logic               done,
    output logic signed [15:0] result_value,
    output logic [15:0]        result_wavelength,
    output logic [2:0]         status
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DSET = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_DFIN = 7'b0100000,
        S_POST = 7'b1000000
    } state_t;

    logic [31:0] mem [MAX_POINTS];
    logic [31:0] rd_data_reg;
    logic               mem_we;
    logic [PT_AW-1:0]   mem_raddr;

    state_t             state_reg, state_next;
    logic [PT_CW-1:0]   count_reg, count_next;
    logic [PT_CW-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic               have_prev_reg, have_prev_next;
    logic               phase_reg, phase_next;
    logic [DIV_CW-1:0]  step_reg, step_next;
    logic               done_reg, done_next;

    logic [15:0]        q_reg, q_next;
    logic signed [15:0] smp_reg, smp_next;
    logic               corr_reg, corr_next;
    logic [15:0]        prev_w_reg, prev_w_next;
    logic signed [15:0] prev_v_reg, prev_v_next;
    logic signed [15:0] v1_reg, v1_next;
    logic signed [16:0] dv_reg, dv_next;
    logic signed [16:0] dq_reg, dq_next;
    logic signed [16:0] dw_reg, dw_next;
    logic signed [33:0] prod_reg, prod_next;
    logic signed [15:0] bias_reg, bias_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [15:0]        rem_reg, rem_next;
    logic [15:0]        dsor_reg, dsor_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] res_val_reg, res_val_next;
    logic [15:0]        res_wl_reg, res_wl_next;
    logic [2:0]         status_reg, status_next;

    logic [15:0]        cur_w;
    logic signed [15:0] cur_v;
    logic               pair_hit, match_hit;
    logic signed [DVD_W-1:0] n_s;
    logic signed [16:0] d_s;
    logic [DVD_W-1:0]   n_abs;
    logic [16:0]        d_abs;
    logic [16:0]        trial;
    logic               ge;
    logic signed [35:0] q_s;
    logic signed [35:0] interp_r;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[PT_AW-1:0]] <= {wavelength, sample_value};
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign mem_raddr = issue_reg[PT_AW-1:0];
    assign cur_w     = rd_data_reg[31:16];
    assign cur_v     = rd_data_reg[15:0];
    assign match_hit = (q_reg == cur_w);
    assign pair_hit  = have_prev_reg &&
                       (((q_reg > prev_w_reg) && (q_reg < cur_w)) ||
                        ((q_reg < prev_w_reg) && (q_reg > cur_w)));

    // divider operands: interpolation quotient or sample correction
    assign n_s   = phase_reg ? {{7{smp_reg[15]}}, smp_reg, 12'b0}
                             : {prod_reg[33], prod_reg};
    assign d_s   = phase_reg ? {bias_reg[15], bias_reg} : dw_reg;
    assign n_abs = n_s[DVD_W-1] ? DVD_W'(-n_s) : DVD_W'(n_s);
    assign d_abs = d_s[16] ? 17'(-d_s) : 17'(d_s);

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = (trial >= {1'b0, dsor_reg});

    assign q_s      = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign interp_r = {{20{v1_reg[15]}}, v1_reg} + q_s;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        have_prev_next = have_prev_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        done_next      = 1'b0;
        q_next         = q_reg;
        smp_next       = smp_reg;
        corr_next      = corr_reg;
        prev_w_next    = prev_w_reg;
        prev_v_next    = prev_v_reg;
        v1_next        = v1_reg;
        dv_next        = dv_reg;
        dq_next        = dq_reg;
        dw_next        = dw_reg;
        prod_next      = prod_reg;
        bias_next      = bias_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsor_next      = dsor_reg;
        neg_next       = neg_reg;
        res_val_next   = res_val_reg;
        res_wl_next    = res_wl_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_wl_next = wavelength;
                    q_next      = wavelength;
                    smp_next    = sample_value;
                    corr_next   = (mode == MODE_CORRECT);
                    case (mode)
                        MODE_CLEAR:
                        begin
                            count_next   = '0;
                            res_val_next = '0;
                            status_next  = ST_OK;
                            done_next    = 1'b1;
                        end
                        MODE_LOAD:
                        begin
                            res_val_next = '0;
                            done_next    = 1'b1;
                            if (count_reg < PT_CW'(MAX_POINTS))
                            begin
                                mem_we      = 1'b1;
                                count_next  = count_reg + PT_CW'(1);
                                status_next = ST_OK;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        default:
                        begin
                            issue_next     = '0;
                            pend_next      = 1'b0;
                            have_prev_next = 1'b0;
                            phase_next     = 1'b0;
                            state_next     = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (pend_reg && pair_hit)
                begin
                    v1_next    = cur_v;
                    dv_next    = {cur_v[15], cur_v} - {prev_v_reg[15], prev_v_reg};
                    dq_next    = $signed({1'b0, q_reg} - {1'b0, cur_w});
                    dw_next    = $signed({1'b0, cur_w} - {1'b0, prev_w_reg});
                    state_next = S_MUL;
                end
                else if (pend_reg && match_hit)
                begin
                    bias_next  = cur_v;
                    state_next = S_POST;
                end
                else if (!pend_reg && (issue_reg == count_reg))
                begin
                    res_val_next = '0;
                    status_next  = ST_RANGE;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    if (issue_reg < count_reg)
                    begin
                        issue_next = issue_reg + PT_CW'(1);
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                    if (pend_reg)
                    begin
                        prev_w_next    = cur_w;
                        prev_v_next    = cur_v;
                        have_prev_next = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = dv_reg * dq_reg;
                state_next = S_DSET;
            end
            S_DSET:
            begin
                dsor_next  = d_abs[15:0];
                dvd_next   = n_abs + DVD_W'(d_abs[15:1]);
                neg_next   = n_s[DVD_W-1] ^ d_s[16];
                rem_next   = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? 16'(trial - {1'b0, dsor_reg}) : trial[15:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], ge};
                step_next = step_reg + DIV_CW'(1);
                if (step_reg == DIV_CW'(DVD_W - 1))
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                if (!phase_reg)
                begin
                    bias_next  = sat16(interp_r);
                    state_next = S_POST;
                end
                else
                begin
                    res_val_next = sat16(q_s);
                    status_next  = out16(q_s) ? ST_SAT : ST_OK;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_POST:
            begin
                if (!corr_reg)
                begin
                    res_val_next = bias_reg;
                    status_next  = ST_OK;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (bias_reg == 16'sd0)
                begin
                    res_val_next = '0;
                    status_next  = ST_DIV0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_DSET;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            have_prev_reg <= have_prev_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        smp_reg     <= smp_next;
        corr_reg    <= corr_next;
        prev_w_reg  <= prev_w_next;
        prev_v_reg  <= prev_v_next;
        v1_reg      <= v1_next;
        dv_reg      <= dv_next;
        dq_reg      <= dq_next;
        dw_reg      <= dw_next;
        prod_reg    <= prod_next;
        bias_reg    <= bias_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dsor_reg    <= dsor_next;
        neg_reg     <= neg_next;
        res_val_reg <= res_val_next;
        res_wl_reg  <= res_wl_next;
        status_reg  <= status_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign result_value      = res_val_reg;
    assign result_wavelength = res_wl_reg;
    assign status            = status_reg;

endmodule

// ===== src/tlic_checker.sv =====
// Port-level checker for the interpolation table top level, with its bind.
// Depends on tlic_pkg and table_linear_interpolate_correct_top.
module tlic_checker
    import tlic_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic [1:0]         mode,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] result_value,
    input logic [2:0]         status
);

    a_table_cmd_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((mode == MODE_CLEAR) || (mode == MODE_LOAD))
        |=> done && !busy)
        else $error("table command transfer without result next cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((mode == MODE_INTERP) || (mode == MODE_CORRECT))
        |=> busy && !done)
        else $error("query transfer did not start a busy period");

    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy period ended without a result");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((status == ST_RANGE) || (status == ST_DIV0)) |-> result_value == 16'sd0)
        else $error("nonzero value with range or divide status");

endmodule

bind table_linear_interpolate_correct_top tlic_checker u_tlic_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for table_linear_interpolate_correct_top: a scoreboard class tracks
// the point table, predicts every result and checks it as it arrives; tasks drive the commands.
// Depends on tlic_pkg and the top level in src.
module testbench;
    import tlic_pkg::*;

    typedef struct {
        logic signed [15:0] value;
        logic [15:0]        wl;
        logic [2:0]         status;
    } result_t;

    class interp_table_model;
        logic [15:0]        pt_wl [MAX_POINTS];
        logic signed [15:0] pt_val [MAX_POINTS];
        int unsigned        pt_count;
        result_t            pending_results [$];
        int unsigned        mismatches;
        int unsigned        results_checked;
        int unsigned        mode_seen [4];
        int unsigned        status_seen [8];

        function new();
            pt_count = 0;
            mismatches = 0;
            results_checked = 0;
            foreach (mode_seen[i])
            begin
                mode_seen[i] = 0;
            end
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
            end
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        // nearest, ties away from zero
        function longint div_near(input longint n, input longint d);
            longint an;
            longint ad;
            longint q;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q = (an + ad / 2) / ad;
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function bit interp_at(input logic [15:0] q, output int val);
            int     qi;
            int     w0;
            int     w1;
            int     v0;
            int     v1;
            longint r;
            qi = int'(q);
            val = 0;
            for (int i = 0; i < pt_count; i++)
            begin
                w0 = int'(pt_wl[i]);
                v0 = pt_val[i];
                if (qi == w0)
                begin
                    val = v0;
                    return 1'b1;
                end
                if (i + 1 >= pt_count)
                begin
                    break;
                end
                w1 = int'(pt_wl[i + 1]);
                v1 = pt_val[i + 1];
                if ((qi > w0 && qi < w1) || (qi < w0 && qi > w1))
                begin
                    r = longint'(v1) + div_near(longint'(v1 - v0) * longint'(qi - w1),
                                                longint'(w1 - w0));
                    if (r > 32767)
                    begin
                        r = 32767;
                    end
                    if (r < -32768)
                    begin
                        r = -32768;
                    end
                    val = int'(r);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        task apply_command(input logic [1:0] m, input logic [15:0] w,
                           input logic signed [15:0] s);
            result_t exp;
            int      val;
            int      bias;
            longint  r;
            val = 0;
            exp.wl = w;
            exp.status = ST_OK;
            case (m)
                MODE_CLEAR:
                begin
                    pt_count = 0;
                end
                MODE_LOAD:
                begin
                    if (pt_count < MAX_POINTS)
                    begin
                        pt_wl[pt_count] = w;
                        pt_val[pt_count] = s;
                        pt_count++;
                    end
                    else
                    begin
                        exp.status = ST_FULL;
                    end
                end
                MODE_INTERP:
                begin
                    if (!interp_at(w, val))
                    begin
                        val = 0;
                        exp.status = ST_RANGE;
                    end
                end
                default:
                begin
                    if (!interp_at(w, bias))
                    begin
                        exp.status = ST_RANGE;
                    end
                    else if (bias == 0)
                    begin
                        exp.status = ST_DIV0;
                    end
                    else
                    begin
                        r = div_near(longint'(s) * 4096, longint'(bias));
                        if (r > 32767)
                        begin
                            r = 32767;
                            exp.status = ST_SAT;
                        end
                        else if (r < -32768)
                        begin
                            r = -32768;
                            exp.status = ST_SAT;
                        end
                        val = int'(r);
                    end
                end
            endcase
            exp.value = val[15:0];
            pending_results = {pending_results, exp};
            mode_seen[m]++;
        endtask

        task check_result(input logic signed [15:0] value, input logic [15:0] w,
                          input logic [2:0] st);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %0d wl %h status %0d",
                                          value, w, st));
            end
            else
            begin
                exp = pending_results.pop_front();
                results_checked++;
                if (!$isunknown(st))
                begin
                    status_seen[st]++;
                end
                if (value !== exp.value)
                begin
                    report_mismatch($sformatf("result_value %0d, expected %0d (wl %h)",
                                              value, exp.value, exp.wl));
                end
                if (w !== exp.wl)
                begin
                    report_mismatch($sformatf("result_wavelength %h, expected %h", w, exp.wl));
                end
                if (st !== exp.status)
                begin
                    report_mismatch($sformatf("status %0d, expected %0d (wl %h)",
                                              st, exp.status, exp.wl));
                end
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [1:0]         mode;
    logic [15:0]        wavelength;
    logic signed [15:0] sample_value;
    logic               busy;
    logic               done;
    logic signed [15:0] result_value;
    logic [15:0]        result_wavelength;
    logic [2:0]         status;

    interp_table_model tbl;
    bit                no_gaps;

    table_linear_interpolate_correct_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .mode              (mode),
        .wavelength        (wavelength),
        .sample_value      (sample_value),
        .busy              (busy),
        .done              (done),
        .result_value      (result_value),
        .result_wavelength (result_wavelength),
        .status            (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            tbl.check_result(result_value, result_wavelength, status);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 65)
        begin
            return 0;
        end
        else if (r < 95)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    task automatic pause(input int unsigned n);
        if (n != 0)
        begin
            start <= 1'b0;
            mode <= 2'($urandom);
            wavelength <= 16'($urandom);
            sample_value <= 16'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] m, input logic [15:0] w,
                         input logic signed [15:0] s);
        if (!no_gaps)
        begin
            pause(pick_gap());
        end
        start <= 1'b1;
        mode <= m;
        wavelength <= w;
        sample_value <= s;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        tbl.apply_command(m, w, s);
    endtask

    function automatic logic signed [15:0] pick_sample();
        int unsigned r;
        r = $urandom_range(9, 0);
        if (r == 0)
        begin
            return 16'sh7fff;
        end
        else if (r == 1)
        begin
            return 16'sh8000;
        end
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] pick_query_mode();
        return ($urandom_range(1, 0) != 0) ? MODE_CORRECT : MODE_INTERP;
    endfunction

    task automatic fill_table();
        logic [15:0] w;
        logic [15:0] first_w;
        int unsigned k;
        no_gaps = 1'b0;
        issue(MODE_CLEAR, 16'($urandom), 16'($urandom));
        w = 16'($urandom_range(255, 0));
        first_w = w;
        for (k = 0; k < MAX_POINTS; k++)
        begin
            issue(MODE_LOAD, w, 16'($urandom));
            if (k != MAX_POINTS - 1)
            begin
                w = w + 16'($urandom_range(250, 1));
            end
        end
        repeat (3) issue(MODE_LOAD, 16'($urandom), pick_sample());
        issue(MODE_INTERP, w, 16'($urandom));
        issue(MODE_CORRECT, w, pick_sample());
        issue(MODE_INTERP, w + 16'd1, 16'($urandom));
        for (k = 0; k < 17; k++)
        begin
            issue(pick_query_mode(), 16'($urandom_range(w, first_w)), pick_sample());
        end
    endtask

    task automatic run_sequence();
        logic [15:0] pts_w [8];
        logic [15:0] w;
        logic [15:0] base;
        int unsigned npts;
        int unsigned nq;
        int unsigned shape;
        int unsigned step;
        int unsigned r;
        int unsigned j;
        int unsigned k;
        logic signed [15:0] v;
        no_gaps = ($urandom_range(4, 0) == 0);
        if ($urandom_range(4, 0) != 0 || tbl.pt_count > 200)
        begin
            issue(MODE_CLEAR, 16'($urandom), 16'($urandom));
        end
        npts = $urandom_range(8, 0);
        shape = $urandom_range(2, 0);
        base = 16'($urandom);
        step = $urandom_range(3000, 1);
        for (k = 0; k < npts; k++)
        begin
            case (shape)
                0: w = 16'(base + k * step);
                1: w = 16'(base - k * step);
                default: w = 16'($urandom);
            endcase
            if (k > 0 && $urandom_range(9, 0) == 0)
            begin
                w = pts_w[k - 1];
            end
            pts_w[k] = w;
            r = $urandom_range(9, 0);
            if (r == 0)
            begin
                v = 16'sd0;
            end
            else if (r == 1)
            begin
                v = $signed(16'($urandom_range(30, 0))) - 16'sd15;
            end
            else
            begin
                v = 16'($urandom);
            end
            issue(MODE_LOAD, w, v);
        end
        nq = $urandom_range(6, 1);
        for (k = 0; k < nq; k++)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                issue(2'($urandom), 16'($urandom), 16'($urandom));
            end
            else
            begin
                r = $urandom_range(9, 0);
                j = (npts > 1) ? $urandom_range(npts - 2, 0) : 0;
                if (npts == 0 || r >= 7)
                begin
                    w = 16'($urandom);
                end
                else if (r <= 2)
                begin
                    w = pts_w[$urandom_range(npts - 1, 0)];
                end
                else if (r <= 5 && npts > 1)
                begin
                    w = 16'($urandom_range(pts_w[j], pts_w[j + 1]));
                end
                else
                begin
                    w = pts_w[j] + (($urandom_range(1, 0) != 0) ? 16'd1 : 16'hffff);
                end
                issue(pick_query_mode(), w, pick_sample());
            end
        end
    endtask

    initial
    begin
        tbl = new();
        no_gaps = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= MODE_CLEAR;
        wavelength <= 16'h0000;
        sample_value <= 16'sh0000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        issue(MODE_INTERP, 16'h1000, 16'sh0000);
        issue(MODE_CORRECT, 16'h1000, 16'sh1000);
        // duplicate first wavelength, ascending pairs, descending pairs
        issue(MODE_LOAD, 16'h0100, 16'sh8000);
        issue(MODE_LOAD, 16'h0100, 16'sh1000);
        issue(MODE_LOAD, 16'h1000, 16'sh7fff);
        issue(MODE_LOAD, 16'h2000, 16'sh0000);
        issue(MODE_LOAD, 16'h0040, 16'sh0001);
        issue(MODE_LOAD, 16'h0020, 16'sh0800);
        issue(MODE_INTERP, 16'h0100, 16'sh7fff);
        issue(MODE_INTERP, 16'h0800, 16'sh0000);
        issue(MODE_INTERP, 16'h0080, 16'sh0000);
        issue(MODE_INTERP, 16'h0020, 16'sh0000);
        issue(MODE_INTERP, 16'hffff, 16'sh0000);
        issue(MODE_INTERP, 16'h0000, 16'sh0000);
        // zero bias, saturation both ways, plain correction, not covered
        issue(MODE_CORRECT, 16'h2000, 16'sh1000);
        issue(MODE_CORRECT, 16'h0040, 16'sh7fff);
        issue(MODE_CORRECT, 16'h0040, 16'sh8000);
        issue(MODE_CORRECT, 16'h1000, 16'sh4000);
        issue(MODE_CORRECT, 16'h0000, 16'sh7fff);
        issue(MODE_CLEAR, 16'hffff, 16'sh8000);
        issue(MODE_INTERP, 16'h0100, 16'sh0000);

        fill_table();
        while (tbl.mode_seen[0] + tbl.mode_seen[1] + tbl.mode_seen[2]
               + tbl.mode_seen[3] < 550)
        begin
            run_sequence();
        end

        pause(1);
        while (tbl.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);

        $display("Transfers: %0d clear, %0d load, %0d interpolate, %0d correct; %0d results",
                 tbl.mode_seen[0], tbl.mode_seen[1], tbl.mode_seen[2], tbl.mode_seen[3],
                 tbl.results_checked);
        $display("Status: ok %0d, range %0d, div0 %0d, full %0d, sat %0d; mismatches %0d",
                 tbl.status_seen[ST_OK], tbl.status_seen[ST_RANGE], tbl.status_seen[ST_DIV0],
                 tbl.status_seen[ST_FULL], tbl.status_seen[ST_SAT], tbl.mismatches);
        if (tbl.mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", tbl.pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
